[rtl/dmk_pkg.sv]
// shared types and constants for the difference matte keyer
package dmk_pkg;

  // default channel width
  localparam int ChannelBitsDef = 16;

  // configuration port geometry
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // register indexes, taken from paddr[2]
  localparam logic RegTolerance = 1'b0;
  localparam logic RegFalloff   = 1'b1;

  // how the final alpha is picked for one pixel
  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_RAMP,
    MODE_ALPHA
  } dmk_mode_e;

  // control that travels with each beat down the pipe
  typedef struct packed {
    logic      valid;
    dmk_mode_e mode;
  } dmk_ctl_t;

endpackage

[rtl/dmk_front.sv]
// front end: channel differences, mean of three, threshold compare
module dmk_front #(
  parameter int ChBits = dmk_pkg::ChannelBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [ChBits-1:0] fg_red_i,
  input  logic [ChBits-1:0] fg_green_i,
  input  logic [ChBits-1:0] fg_blue_i,
  input  logic [ChBits-1:0] fg_alpha_i,
  input  logic [ChBits-1:0] bg_red_i,
  input  logic [ChBits-1:0] bg_green_i,
  input  logic [ChBits-1:0] bg_blue_i,
  input  logic [ChBits-1:0] tolerance_i,
  input  logic [ChBits-1:0] falloff_i,
  input  logic              ready_i,
  output dmk_pkg::dmk_ctl_t ctl_o,
  output logic [ChBits-1:0] alpha_o,
  output logic [ChBits-1:0] rem_o
);

  localparam int SumW     = ChBits + 2;
  localparam int DivShift = ChBits + 3;
  localparam int ProdW    = SumW + DivShift;
  // ceil(2^DivShift / 3), exact for every sum below 3 * 2^ChBits
  localparam longint unsigned RecipVal = ((64'd1 << DivShift) + 64'd2) / 64'd3;
  localparam logic [DivShift-1:0] Recip = DivShift'(RecipVal);

  function automatic logic [ChBits-1:0] abs_diff(input logic [ChBits-1:0] a,
                                                 input logic [ChBits-1:0] b);
    logic [ChBits-1:0] r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

  logic              s1_valid_q;
  logic [SumW-1:0]   s1_sum_q, s1_sum_d;
  logic [ChBits-1:0] s1_alpha_q;
  logic              s2_valid_q;
  logic [ChBits-1:0] s2_diff_q, s2_diff_d;
  logic [ChBits-1:0] s2_alpha_q;
  dmk_pkg::dmk_ctl_t s3_ctl_q, s3_ctl_d;
  logic [ChBits-1:0] s3_alpha_q;
  logic [ChBits-1:0] s3_rem_q, s3_rem_d;
  logic [ProdW-1:0]  prod;
  logic [ChBits:0]   upper;
  logic              s1_rdy, s2_rdy, s3_rdy;

  // ready chain, a bubble anywhere lets upstream move
  assign s3_rdy  = !s3_ctl_q.valid || ready_i;
  assign s2_rdy  = !s2_valid_q || s3_rdy;
  assign s1_rdy  = !s1_valid_q || s2_rdy;
  assign ready_o = s1_rdy;

  // sum of absolute channel differences
  assign s1_sum_d = SumW'(abs_diff(bg_red_i, fg_red_i))
                  + SumW'(abs_diff(bg_green_i, fg_green_i))
                  + SumW'(abs_diff(bg_blue_i, fg_blue_i));

  // divide by three through the reciprocal
  assign prod      = ProdW'(s1_sum_q) * ProdW'(Recip);
  assign s2_diff_d = prod[DivShift +: ChBits];

  // classify against tolerance and ramp end
  assign upper = {1'b0, tolerance_i} + {1'b0, falloff_i};
  always_comb begin
    s3_ctl_d.valid = s2_valid_q;
    s3_rem_d       = s2_diff_q - tolerance_i;
    priority if (s2_diff_q < tolerance_i) begin
      s3_ctl_d.mode = dmk_pkg::MODE_ZERO;
    end else if (({1'b0, s2_diff_q} < upper) && (falloff_i != '0)) begin
      s3_ctl_d.mode = dmk_pkg::MODE_RAMP;
    end else begin
      s3_ctl_d.mode = dmk_pkg::MODE_ALPHA;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      s3_ctl_q.valid <= 1'b0;
      s3_ctl_q.mode  <= dmk_pkg::MODE_ZERO;
    end else begin
      if (s1_rdy) begin
        s1_valid_q <= valid_i;
      end
      if (s2_rdy) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_rdy) begin
        s3_ctl_q <= s3_ctl_d;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (s1_rdy && valid_i) begin
      s1_sum_q   <= s1_sum_d;
      s1_alpha_q <= fg_alpha_i;
    end
    if (s2_rdy && s1_valid_q) begin
      s2_diff_q  <= s2_diff_d;
      s2_alpha_q <= s1_alpha_q;
    end
    if (s3_rdy && s2_valid_q) begin
      s3_alpha_q <= s2_alpha_q;
      s3_rem_q   <= s3_rem_d;
    end
  end

  assign ctl_o   = s3_ctl_q;
  assign alpha_o = s3_alpha_q;
  assign rem_o   = s3_rem_q;

endmodule

[rtl/dmk_div_cell.sv]
// one restoring divide cell: one quotient bit per cell
module dmk_div_cell #(
  parameter int ChBits = dmk_pkg::ChannelBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dmk_pkg::dmk_ctl_t ctl_i,
  input  logic [ChBits-1:0] alpha_i,
  input  logic [ChBits-1:0] rem_i,
  input  logic [ChBits-1:0] quo_i,
  input  logic [ChBits-1:0] divisor_i,
  input  logic              ready_i,
  output logic              ready_o,
  output dmk_pkg::dmk_ctl_t ctl_o,
  output logic [ChBits-1:0] alpha_o,
  output logic [ChBits-1:0] rem_o,
  output logic [ChBits-1:0] quo_o
);

  dmk_pkg::dmk_ctl_t ctl_q;
  logic [ChBits-1:0] alpha_q;
  logic [ChBits-1:0] rem_q, rem_d;
  logic [ChBits-1:0] quo_q, quo_d;
  logic [ChBits:0]   rem2;
  logic [ChBits:0]   rem_sub;
  logic              fits;

  assign ready_o = !ctl_q.valid || ready_i;

  // shift in a zero numerator bit, subtract when it fits
  assign rem2    = {rem_i, 1'b0};
  assign rem_sub = rem2 - {1'b0, divisor_i};
  assign fits    = rem2 >= {1'b0, divisor_i};
  assign rem_d   = fits ? rem_sub[ChBits-1:0] : rem2[ChBits-1:0];
  assign quo_d   = {quo_i[ChBits-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.valid <= 1'b0;
      ctl_q.mode  <= dmk_pkg::MODE_ZERO;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      alpha_q <= alpha_i;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign alpha_o = alpha_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

[rtl/difference_matte_key_unit.sv]
// input beat to valid_o: three front stages, one divide cell per quotient bit,
// one output register
// throughput: one pixel per cycle while the output is not stalled, set by the row of
// divide cells; a stalled output holds the pipe only as far back as there are no bubbles
// reset: asynchronous active-low, clears all beat valids and sets tolerance and falloff to 0
module difference_matte_key_unit #(
  parameter int CHANNEL_BITS = dmk_pkg::ChannelBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmk_pkg::ApbAddrW-1:0] paddr,
  input  logic [dmk_pkg::ApbDataW-1:0] pwdata,
  output logic [dmk_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  // pixel input
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [CHANNEL_BITS-1:0]      fg_red_i,
  input  logic [CHANNEL_BITS-1:0]      fg_green_i,
  input  logic [CHANNEL_BITS-1:0]      fg_blue_i,
  input  logic [CHANNEL_BITS-1:0]      fg_alpha_i,
  input  logic [CHANNEL_BITS-1:0]      bg_red_i,
  input  logic [CHANNEL_BITS-1:0]      bg_green_i,
  input  logic [CHANNEL_BITS-1:0]      bg_blue_i,
  // matte output
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [CHANNEL_BITS-1:0]      matte_alpha_o
);

  localparam int NumCells = CHANNEL_BITS;

  logic [CHANNEL_BITS-1:0] tolerance_q;
  logic [CHANNEL_BITS-1:0] falloff_q;
  logic                    cfg_wr;

  dmk_pkg::dmk_ctl_t       ctl_w   [0:NumCells];
  logic [CHANNEL_BITS-1:0] alpha_w [0:NumCells];
  logic [CHANNEL_BITS-1:0] rem_w   [0:NumCells];
  logic [CHANNEL_BITS-1:0] quo_w   [0:NumCells];
  logic                    rdy_w   [0:NumCells];
  logic                    front_rdy;

  logic                    out_valid_q;
  logic [CHANNEL_BITS-1:0] matte_q, matte_d;
  logic                    out_rdy;

  // register writes and reads
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= '0;
      falloff_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        dmk_pkg::RegTolerance: tolerance_q <= pwdata[CHANNEL_BITS-1:0];
        dmk_pkg::RegFalloff:   falloff_q   <= pwdata[CHANNEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      dmk_pkg::RegTolerance: prdata[CHANNEL_BITS-1:0] = tolerance_q;
      dmk_pkg::RegFalloff:   prdata[CHANNEL_BITS-1:0] = falloff_q;
      default: ;
    endcase
  end

  // front end
  dmk_front #(
    .ChBits(CHANNEL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .ready_o    (front_rdy),
    .fg_red_i   (fg_red_i),
    .fg_green_i (fg_green_i),
    .fg_blue_i  (fg_blue_i),
    .fg_alpha_i (fg_alpha_i),
    .bg_red_i   (bg_red_i),
    .bg_green_i (bg_green_i),
    .bg_blue_i  (bg_blue_i),
    .tolerance_i(tolerance_q),
    .falloff_i  (falloff_q),
    .ready_i    (rdy_w[0]),
    .ctl_o      (ctl_w[0]),
    .alpha_o    (alpha_w[0]),
    .rem_o      (rem_w[0])
  );

  assign stall_o  = !front_rdy;
  assign quo_w[0] = '0;

  // row of divide cells, MSB of the quotient first
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    dmk_div_cell #(
      .ChBits(CHANNEL_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl_w[k]),
      .alpha_i  (alpha_w[k]),
      .rem_i    (rem_w[k]),
      .quo_i    (quo_w[k]),
      .divisor_i(falloff_q),
      .ready_i  (rdy_w[k+1]),
      .ready_o  (rdy_w[k]),
      .ctl_o    (ctl_w[k+1]),
      .alpha_o  (alpha_w[k+1]),
      .rem_o    (rem_w[k+1]),
      .quo_o    (quo_w[k+1])
    );
  end

  // final pick, ramp capped at foreground alpha
  assign out_rdy         = !out_valid_q || !stall_i;
  assign rdy_w[NumCells] = out_rdy;

  always_comb begin
    unique case (ctl_w[NumCells].mode)
      dmk_pkg::MODE_ZERO:  matte_d = '0;
      dmk_pkg::MODE_RAMP:  matte_d = (quo_w[NumCells] < alpha_w[NumCells]) ?
                                     quo_w[NumCells] : alpha_w[NumCells];
      dmk_pkg::MODE_ALPHA: matte_d = alpha_w[NumCells];
      default:             matte_d = alpha_w[NumCells];
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= ctl_w[NumCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && ctl_w[NumCells].valid) begin
      matte_q <= matte_d;
    end
  end

  assign valid_o       = out_valid_q;
  assign matte_alpha_o = matte_q;

`ifndef SYNTH
  // input only backs up when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled while the pipe has room");

  // a new output beat always comes from the last cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_rdy && !ctl_w[NumCells].valid) |=> !valid_o)
    else $error("output beat appeared without a source beat");

  // pixels below tolerance come out fully transparent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_rdy && ctl_w[NumCells].valid && ctl_w[NumCells].mode == dmk_pkg::MODE_ZERO)
    |=> (valid_o && matte_alpha_o == '0))
    else $error("transparent pixel produced nonzero alpha");

  // a ramp beat reaching the end always carries a quotient within alpha after capping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_rdy && ctl_w[NumCells].valid && ctl_w[NumCells].mode == dmk_pkg::MODE_RAMP)
    |=> (matte_alpha_o <= $past(alpha_w[NumCells])))
    else $error("ramp alpha exceeds foreground alpha");
`endif

endmodule
